// ===== rtl/core/dplm_pkg.sv =====
// ----------------------------------------------------------------------------
// dplm_pkg
// Shared types and constants of the demand-paging MMU with local LRU
// replacement.
// ----------------------------------------------------------------------------
`default_nettype none
package dplm_pkg;

  localparam int NUM_PROCS      = 8;
  localparam int PAGES_PER_PROC = 64;
  localparam int NUM_FRAMES     = 256;
  localparam int TABLE_SIZE     = NUM_PROCS * PAGES_PER_PROC;

  localparam int PROC_W  = 3;
  localparam int PAGE_W  = 6;
  localparam int FRAME_W = 8;
  localparam int STAMP_W = 32;
  localparam int LIMIT_W = 7;
  localparam int IDX_W   = PROC_W + PAGE_W;
  localparam int COUNT_W = 9;

  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_PUSH   = 2'd2;
  localparam logic [1:0] OP_LIMIT  = 2'd3;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_FAULT    = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_FINISHED = 3'd3;
  localparam logic [2:0] ST_PUSHED   = 3'd4;
  localparam logic [2:0] ST_LIMIT    = 3'd5;
  localparam logic [2:0] ST_NOFRAME  = 3'd6;

  typedef struct packed {
    logic [1:0]         op;
    logic [PROC_W-1:0]  proc_id;
    logic [PAGE_W-1:0]  page_num;
    logic [7:0]         value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [FRAME_W-1:0] frame_out;
    logic [PROC_W-1:0]  proc_out;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [STAMP_W-1:0] stamp;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ===== rtl/core/dplm_ram.sv =====
// ----------------------------------------------------------------------------
// dplm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module dplm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/demand_paging_local_lru_mmu.sv =====
// ----------------------------------------------------------------------------
// demand_paging_local_lru_mmu
// Per-process page tables in one RAM, free frames in a stack RAM, LRU victim
// search and frame release by sequential scan of the process's table.
// ----------------------------------------------------------------------------
// Push and set-limit complete in S_IDLE; a hit goes through S_LOOK, a fault
// from the stack through S_LOOK and S_POP. A victim search or a release scans
// 64 table entries through the RAM read port, one per cycle; an eviction then
// writes in S_EVICT and S_FILL. One transaction at a time.
// The result strobe is high for one cycle; the receiver cannot stall it.
// After reset a clearing pass zeroes all 512 page-table entries, busy high.
`default_nettype none
module demand_paging_local_lru_mmu
  import dplm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire cmd_t    cmd,
  output logic         done,
  output result_t      result
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_POP, S_SCAN, S_EVICT, S_FILL
  } state_t;

  state_t                state;
  logic [IDX_W:0]        clr_cnt;
  logic [COUNT_W-1:0]    count;
  logic [STAMP_W-1:0]    time_now;
  logic [LIMIT_W-1:0]    page_limit [NUM_PROCS];
  logic [PROC_W-1:0]     proc;
  logic [PAGE_W-1:0]     page;
  logic                  release_mode;
  logic [2:0]            rel_status;
  logic [PAGE_W:0]       scan_cnt;
  logic                  pend;
  logic [PAGE_W-1:0]     pend_idx;
  logic                  found;
  logic [STAMP_W-1:0]    best;
  logic [PAGE_W-1:0]     victim;
  logic [FRAME_W-1:0]    vframe;

  logic                  pt_we;
  logic [IDX_W-1:0]      pt_waddr, pt_raddr;
  entry_t                pt_wdata, pt_rdata;
  logic                  st_we;
  logic [7:0]            st_waddr, st_raddr;
  logic [FRAME_W-1:0]    st_wdata, st_rdata;

  logic [STAMP_W-1:0]    time_inc;
  logic                  take_slot;

  assign busy      = (state != S_IDLE);
  assign time_inc  = (time_now == '1) ? time_now : time_now + 1'b1;
  assign take_slot = pend && pt_rdata.valid && release_mode;

  dplm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_table (
    .clk, .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  dplm_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_stack (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = {proc, page};
    pt_wdata = '0;
    pt_raddr = {cmd.proc_id, cmd.page_num};
    st_we    = 1'b0;
    st_waddr = count[7:0];
    st_wdata = cmd.value;
    st_raddr = count[7:0] - 8'd1;
    case (state)
      S_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_cnt[IDX_W-1:0];
      end
      S_IDLE: begin
        st_we = start && (cmd.op == OP_PUSH) && !count[COUNT_W-1];
      end
      S_LOOK: begin
        pt_we    = pt_rdata.valid;
        pt_wdata = '{valid: 1'b1, stamp: time_now, frame: pt_rdata.frame};
      end
      S_POP: begin
        pt_we    = 1'b1;
        pt_wdata = '{valid: 1'b1, stamp: time_now, frame: st_rdata};
      end
      S_SCAN: begin
        pt_raddr = {proc, scan_cnt[PAGE_W-1:0]};
        if (take_slot) begin
          pt_we          = 1'b1;
          pt_waddr       = {proc, pend_idx};
          pt_wdata       = pt_rdata;
          pt_wdata.valid = 1'b0;
          st_we          = !count[COUNT_W-1];
          st_wdata       = pt_rdata.frame;
        end
      end
      S_EVICT: begin
        pt_we    = 1'b1;
        pt_waddr = {proc, victim};
      end
      S_FILL: begin
        pt_we    = 1'b1;
        pt_wdata = '{valid: 1'b1, stamp: time_now, frame: vframe};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      count    <= '0;
      time_now <= '0;
      pend     <= 1'b0;
      for (int i = 0; i < NUM_PROCS; i++) begin
        page_limit[i] <= '0;
      end
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (IDX_W+1)'(TABLE_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            proc            <= cmd.proc_id;
            page            <= cmd.page_num;
            result.proc_out <= cmd.proc_id;
            result.frame_out <= '0;
            scan_cnt        <= '0;
            pend            <= 1'b0;
            found           <= 1'b0;
            case (cmd.op)
              OP_ACCESS: begin
                time_now <= time_inc;
                if ({1'b0, cmd.page_num} >= page_limit[cmd.proc_id]) begin
                  release_mode <= 1'b1;
                  rel_status   <= ST_INVALID;
                  state        <= S_SCAN;
                end else begin
                  state <= S_LOOK;
                end
              end
              OP_FINISH: begin
                time_now     <= time_inc;
                release_mode <= 1'b1;
                rel_status   <= ST_FINISHED;
                state        <= S_SCAN;
              end
              OP_PUSH: begin
                if (!count[COUNT_W-1]) begin
                  count <= count + 1'b1;
                end
                done          <= 1'b1;
                result.status <= ST_PUSHED;
              end
              default: begin
                page_limit[cmd.proc_id] <= (cmd.value > 8'd127) ? 7'd127
                                                                : cmd.value[6:0];
                done          <= 1'b1;
                result.status <= ST_LIMIT;
              end
            endcase
          end
        end
        S_LOOK: begin
          if (pt_rdata.valid) begin
            done             <= 1'b1;
            result.status    <= ST_HIT;
            result.frame_out <= pt_rdata.frame;
            state            <= S_IDLE;
          end else if (count != '0) begin
            state <= S_POP;
          end else begin
            release_mode <= 1'b0;
            state        <= S_SCAN;
          end
        end
        S_POP: begin
          count         <= count - 1'b1;
          done          <= 1'b1;
          result.status <= ST_FAULT;
          state         <= S_IDLE;
        end
        S_SCAN: begin
          // Read of entry scan_cnt is issued now; data of pend_idx arrives now.
          if (take_slot && !count[COUNT_W-1]) begin
            count <= count + 1'b1;
          end
          if (pend && !release_mode && pt_rdata.valid &&
              (!found || pt_rdata.stamp < best)) begin
            found  <= 1'b1;
            best   <= pt_rdata.stamp;
            victim <= pend_idx;
            vframe <= pt_rdata.frame;
          end
          if (!scan_cnt[PAGE_W]) begin
            pend     <= 1'b1;
            pend_idx <= scan_cnt[PAGE_W-1:0];
            scan_cnt <= scan_cnt + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (scan_cnt[PAGE_W] && !pend) begin
            if (release_mode) begin
              done          <= 1'b1;
              result.status <= rel_status;
              state         <= S_IDLE;
            end else if (!found) begin
              done          <= 1'b1;
              result.status <= ST_NOFRAME;
              state         <= S_IDLE;
            end else begin
              state <= S_EVICT;
            end
          end
        end
        S_EVICT: begin
          state <= S_FILL;
        end
        S_FILL: begin
          done          <= 1'b1;
          result.status <= ST_FAULT;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the demand-paging MMU with local LRU replacement.
// Commands go in one at a time; each result is compared with a predicted one
// from a behavioral copy of the page tables, free stack and timestamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;
  import dplm_pkg::*;

  // Behavioral copy of the MMU; predicts the result of each command.
  class mmu_scoreboard;
    logic [FRAME_W-1:0] frame_of[TABLE_SIZE];
    bit                 present[TABLE_SIZE];
    logic [STAMP_W-1:0] stamp_of[TABLE_SIZE];
    logic [FRAME_W-1:0] free_frames[NUM_FRAMES];
    int                 free_cnt;
    logic [LIMIT_W-1:0] limit_of[NUM_PROCS];
    logic [STAMP_W-1:0] clock_now;
    result_t            pending[$];
    int                 errors;
    int                 checked;
    int                 status_seen[8];

    function new();
      for (int i = 0; i < TABLE_SIZE; i++) begin
        present[i] = 0;
        stamp_of[i] = '0;
        frame_of[i] = '0;
      end
      for (int i = 0; i < NUM_PROCS; i++) limit_of[i] = '0;
      free_cnt = 0;
      clock_now = '0;
      errors = 0;
      checked = 0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
    endfunction

    function void push_free(logic [FRAME_W-1:0] f);
      if (free_cnt < NUM_FRAMES) begin
        free_frames[free_cnt] = f;
        free_cnt++;
      end
    endfunction

    function void release_proc(int p);
      for (int i = 0; i < PAGES_PER_PROC; i++) begin
        if (present[p*PAGES_PER_PROC+i]) begin
          push_free(frame_of[p*PAGES_PER_PROC+i]);
          present[p*PAGES_PER_PROC+i] = 0;
        end
      end
    endfunction

    function logic [2:0] serve_miss(int p, int idx);
      int victim;
      bit found;
      logic [STAMP_W-1:0] best;
      victim = 0;
      found = 0;
      best = '0;
      if (free_cnt > 0) begin
        free_cnt--;
        frame_of[idx] = free_frames[free_cnt];
        present[idx] = 1;
        stamp_of[idx] = clock_now;
        return ST_FAULT;
      end
      for (int i = 0; i < PAGES_PER_PROC; i++) begin
        if (present[p*PAGES_PER_PROC+i] && (!found || stamp_of[p*PAGES_PER_PROC+i] < best)) begin
          found = 1;
          best = stamp_of[p*PAGES_PER_PROC+i];
          victim = p*PAGES_PER_PROC+i;
        end
      end
      if (!found) return ST_NOFRAME;
      present[victim] = 0;
      stamp_of[victim] = '0;
      frame_of[idx] = frame_of[victim];
      present[idx] = 1;
      stamp_of[idx] = clock_now;
      return ST_FAULT;
    endfunction

    function void note_command(cmd_t c);
      result_t r;
      int p;
      int idx;
      p = int'(c.proc_id);
      r.status = ST_HIT;
      r.frame_out = '0;
      r.proc_out = c.proc_id;
      case (c.op)
        OP_ACCESS: begin
          if (clock_now != '1) clock_now++;
          if (c.page_num >= limit_of[p]) begin
            release_proc(p);
            r.status = ST_INVALID;
          end else begin
            idx = p*PAGES_PER_PROC + int'(c.page_num);
            if (present[idx]) begin
              stamp_of[idx] = clock_now;
              r.frame_out = frame_of[idx];
              r.status = ST_HIT;
            end else begin
              r.status = serve_miss(p, idx);
            end
          end
        end
        OP_FINISH: begin
          if (clock_now != '1) clock_now++;
          release_proc(p);
          r.status = ST_FINISHED;
        end
        OP_PUSH: begin
          push_free(c.value);
          r.status = ST_PUSHED;
        end
        default: begin
          limit_of[p] = (c.value > 127) ? 7'd127 : c.value[LIMIT_W-1:0];
          r.status = ST_LIMIT;
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d frame=%0d proc=%0d", $time,
                 got.status, got.frame_out, got.proc_out);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      status_seen[want.status]++;
      if (got.status !== want.status)
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      if (got.frame_out !== want.frame_out)
        $display("%0t: frame_out expected %0d actual %0d", $time, want.frame_out,
                 got.frame_out);
      if (got.proc_out !== want.proc_out)
        $display("%0t: proc_out expected %0d actual %0d", $time, want.proc_out,
                 got.proc_out);
      if (got !== want) errors++;
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    done;
  result_t result;

  mmu_scoreboard board;
  int      send_idle_pct;
  longint  cycles;
  int      sent;

  demand_paging_local_lru_mmu uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Results are sampled at the rising edge; the strobe cannot be held off.
  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("timeout after %0d cycles", cycles);
        $display("demand_paging_local_lru_mmu: mismatch");
        $finish;
      end
    end
  end

  // One transaction: drive at the falling edge, hold until accepted.
  task automatic send_cmd(logic [1:0] op, int p, int pg, int val);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    cmd.op = op;
    cmd.proc_id = PROC_W'(p);
    cmd.page_num = PAGE_W'(pg);
    cmd.value = 8'(val);
    start = 1;
    do @(posedge clk); while (busy);
    board.note_command(cmd);
    sent++;
    @(negedge clk);
    start = 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Mostly well-formed traffic: accesses within limits, few frames so that
  // the stack runs dry and eviction happens often.
  task automatic random_cmd();
    int r;
    int p;
    r = $urandom_range(99);
    p = $urandom_range(7);
    if (r < 70) begin
      if ($urandom_range(9) == 0) send_cmd(OP_ACCESS, p, $urandom_range(63), $urandom);
      else send_cmd(OP_ACCESS, p, $urandom_range(11), $urandom);
    end else if (r < 76) send_cmd(OP_FINISH, p, $urandom_range(63), $urandom);
    else if (r < 90) send_cmd(OP_PUSH, p, $urandom_range(63), $urandom_range(255));
    else if (r < 97) send_cmd(OP_LIMIT, p, $urandom_range(63), $urandom_range(4, 16));
    else send_cmd(OP_LIMIT, p, $urandom_range(63), $urandom_range(255));
  endtask

  initial begin
    board = new();
    rst = 1;
    start = 0;
    cmd = '0;
    send_idle_pct = 0;
    sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: no frames yet, limits at zero, field extremes.
    send_cmd(OP_ACCESS, 0, 0, 0);
    send_cmd(OP_LIMIT, 0, 0, 255);
    send_cmd(OP_LIMIT, 7, 63, 64);
    send_cmd(OP_LIMIT, 1, 0, 2);
    send_cmd(OP_ACCESS, 0, 5, 0);
    send_cmd(OP_PUSH, 0, 0, 8'hff);
    send_cmd(OP_PUSH, 7, 63, 8'h00);
    send_cmd(OP_PUSH, 2, 21, 8'h55);
    send_cmd(OP_ACCESS, 7, 63, 255);
    send_cmd(OP_ACCESS, 7, 63, 0);
    send_cmd(OP_ACCESS, 7, 0, 0);
    send_cmd(OP_ACCESS, 7, 1, 0);
    send_cmd(OP_ACCESS, 7, 0, 0);
    send_cmd(OP_ACCESS, 7, 2, 0);
    send_cmd(OP_ACCESS, 1, 1, 0);
    send_cmd(OP_ACCESS, 7, 3, 0);
    send_cmd(OP_ACCESS, 1, 2, 0);
    send_cmd(OP_FINISH, 7, 0, 0);
    send_cmd(OP_FINISH, 3, 42, 170);
    send_cmd(OP_ACCESS, 0, 63, 0);
    drain();

    // Fill the stack past its depth so pushes get dropped.
    for (int i = 0; i < NUM_FRAMES + 4; i++) send_cmd(OP_PUSH, i % 8, i % 64, i);
    drain();
    for (int i = 0; i < 8; i++) send_cmd(OP_FINISH, i, 0, 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 83 : (ph == 3) ? 11 : 0;
      for (int i = 0; i < 250; i++) random_cmd();
      drain();
    end

    $display("ran %0d commands: %0d hits, %0d faults, %0d no-frame, %0d terminations",
             sent, board.status_seen[ST_HIT], board.status_seen[ST_FAULT],
             board.status_seen[ST_NOFRAME], board.status_seen[ST_INVALID]);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("demand_paging_local_lru_mmu: match");
    else
      $display("demand_paging_local_lru_mmu: mismatch");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/dplm_pkg.sv
rtl/core/dplm_ram.sv
rtl/core/demand_paging_local_lru_mmu.sv
tb/tb.sv
